// ----- rtl/core/dpd_pkg.sv -----
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types and constants for the debug packet deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

   // link characters
   localparam logic [7:0] CH_START = 8'h24;  // '$'
   localparam logic [7:0] CH_END   = 8'h23;  // '#'
   localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
   localparam logic [7:0] CH_NACK  = 8'h2D;  // '-'
   localparam logic [7:0] CH_INTR  = 8'h03;  // ctrl-C

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_INTR    = 2'd2;

   // packet end status
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_CSUM     = 3'd1;
   localparam logic [2:0] ST_BAD_HEX  = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   localparam int LEN_W       = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // token classes passed from front to back
   localparam logic [1:0] TK_DATA  = 2'd0;
   localparam logic [1:0] TK_START = 2'd1;
   localparam logic [1:0] TK_END   = 2'd2;
   localparam logic [1:0] TK_INTR  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [4:0] digit;   // hex value, bit 4 set when not a hex digit
   } token_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       payload;
      logic [LEN_W-1:0] length;
      logic [2:0]       status;
      logic             reply_valid;
      logic [7:0]       reply;
   } result_type;

endpackage

// ----- rtl/core/dpd_front.sv -----
// ----------------------------------------------------------------------------
// dpd_front
// Classifies received bytes into tokens; ack and nack bytes are dropped here.
// ----------------------------------------------------------------------------
module dpd_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               q_ready,
   output logic               q_push,
   output dpd_pkg::token_type q_token
);
   import dpd_pkg::*;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c >= 8'h30 && c <= 8'h39)      v = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
      else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
      return v;
   endfunction

   logic is_ack;

   assign req_ready = q_ready;
   assign is_ack    = (req_rx_byte == CH_ACK) || (req_rx_byte == CH_NACK);
   assign q_push    = req_valid && q_ready && !is_ack;

   always_comb begin
      q_token.data  = req_rx_byte;
      q_token.digit = hex_value(req_rx_byte);
      priority if (req_rx_byte == CH_INTR) begin
         q_token.kind = TK_INTR;
      end else if (req_rx_byte == CH_START) begin
         q_token.kind = TK_START;
      end else if (req_rx_byte == CH_END) begin
         q_token.kind = TK_END;
      end else begin
         q_token.kind = TK_DATA;
      end
   end

endmodule

// ----- rtl/core/dpd_queue.sv -----
// ----------------------------------------------------------------------------
// dpd_queue
// Short token queue between the front and back halves.
// ----------------------------------------------------------------------------
module dpd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dpd_pkg::token_type push_token,
   output logic               ready,
   input  logic               pop,
   output logic               valid,
   output dpd_pkg::token_type head
);
   import dpd_pkg::*;

   token_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;

   assign ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_token;
   end

endmodule

// ----- rtl/core/dpd_back.sv -----
// ----------------------------------------------------------------------------
// dpd_back
// Packet state machine: sums payload, checks the checksum, builds results.
// ----------------------------------------------------------------------------
module dpd_back #(
   parameter int MAX_PAYLOAD = 4095
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                ack_enable,
   input  logic                q_valid,
   input  dpd_pkg::token_type  q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dpd_pkg::result_type rsp_result
);
   import dpd_pkg::*;

   localparam int COUNT_W = $clog2(MAX_PAYLOAD + 1);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_DIGIT1  = 2'd2;
   localparam logic [1:0] PH_DIGIT2  = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [4:0]         high_ff, high_in;
   logic               ovf_ff, ovf_in;
   logic               out_valid_ff;
   result_type         out_ff;
   logic               res_valid;
   result_type         res;
   logic [2:0]         status;

   assign q_pop      = q_valid && (!out_valid_ff || rsp_ready);
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      high_in   = high_ff;
      ovf_in    = ovf_ff;
      res_valid = 1'b0;
      res       = '0;
      status    = ST_OK;
      if (q_pop) begin
         priority if (q_head.kind == TK_INTR) begin
            res_valid = 1'b1;
            res.kind  = KIND_INTR;
         end else if (q_head.kind == TK_START) begin
            phase_in = PH_PAYLOAD;
            sum_in   = '0;
            count_in = '0;
            high_in  = '0;
            ovf_in   = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_PAYLOAD: begin
                  if (q_head.kind == TK_END) begin
                     phase_in = PH_DIGIT1;
                  end else if (count_ff < COUNT_W'(MAX_PAYLOAD)) begin
                     count_in    = count_ff + 1'b1;
                     sum_in      = sum_ff + q_head.data;
                     res_valid   = 1'b1;
                     res.kind    = KIND_PAYLOAD;
                     res.payload = q_head.data;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               PH_DIGIT1: begin
                  high_in  = q_head.digit;
                  phase_in = PH_DIGIT2;
               end
               PH_DIGIT2: begin
                  priority if (count_ff == '0) begin
                     status = ST_EMPTY;
                  end else if (high_ff[4] || q_head.digit[4]) begin
                     status = ST_BAD_HEX;
                  end else if (ovf_ff) begin
                     status = ST_OVERFLOW;
                  end else if ({high_ff[3:0], q_head.digit[3:0]} != sum_ff) begin
                     status = ST_CSUM;
                  end else begin
                     status = ST_OK;
                  end
                  res_valid       = 1'b1;
                  res.kind        = KIND_END;
                  res.length      = LEN_W'(count_ff);
                  res.status      = status;
                  res.reply_valid = (status != ST_EMPTY) && ack_enable;
                  res.reply       = !res.reply_valid ? 8'h00 :
                                    (status == ST_OK) ? CH_ACK : CH_NACK;
                  phase_in = PH_IDLE;
                  sum_in   = '0;
                  count_in = '0;
                  high_in  = '0;
                  ovf_in   = 1'b0;
               end
               PH_IDLE: begin
                  // stray bytes outside a packet are ignored
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         high_ff      <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         ovf_ff   <= ovf_in;
         if (q_pop) begin
            out_valid_ff <= res_valid;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && res_valid) out_ff <= res;
   end

endmodule

// ----- rtl/core/debug_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// debug_packet_deframer
// Byte deframer for a debugger serial link with checksum check and ack reply.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  req_rx_byte
//  rsp      out  rsp_valid/rsp_ready  kind, payload, length, status, reply
//  csr      in   csr_valid/csr_ready  csr_ack_enable
//
//  One byte a cycle sustained while rsp is ready; a result passes the queue, then the output register.
//  The front classifies each byte into a two-word queue; the back state
//  machine drains it into a single output register.
//  A stalled rsp side fills the queue, then drops req_ready.
//  Reset is synchronous; ack_enable comes out of reset set.
// ----------------------------------------------------------------------------
module debug_packet_deframer #(
   parameter int MAX_PAYLOAD = 4095
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_result_kind,
   output logic [7:0]                 rsp_payload_byte,
   output logic [dpd_pkg::LEN_W-1:0]  rsp_packet_length,
   output logic [2:0]                 rsp_end_status,
   output logic                       rsp_reply_valid,
   output logic [7:0]                 rsp_reply_byte,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_ack_enable
);
   import dpd_pkg::*;

   logic       ack_enable_ff;
   logic       q_ready, q_push, q_valid, q_pop;
   token_type  q_token, q_head;
   result_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         ack_enable_ff <= csr_ack_enable;
      end
   end

   dpd_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_token     (q_token)
   );

   dpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_token),
      .ready      (q_ready),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   dpd_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ack_enable (ack_enable_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_result_kind   = result.kind;
   assign rsp_payload_byte  = result.payload;
   assign rsp_packet_length = result.length;
   assign rsp_end_status    = result.status;
   assign rsp_reply_valid   = result.reply_valid;
   assign rsp_reply_byte    = result.reply;

endmodule

// ----- rtl/core/dpd_checker.sv -----
// ----------------------------------------------------------------------------
// dpd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
module dpd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_result_kind,
   input logic [7:0]                rsp_payload_byte,
   input logic [dpd_pkg::LEN_W-1:0] rsp_packet_length,
   input logic [2:0]                rsp_end_status,
   input logic                      rsp_reply_valid,
   input logic [7:0]                rsp_reply_byte
);
   import dpd_pkg::*;

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_packet_length)
         && $stable(rsp_end_status) && $stable(rsp_reply_byte))
      else $error("rsp word changed while stalled");

   a_no_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_END |-> !rsp_reply_valid
         && rsp_end_status == ST_OK && rsp_packet_length == '0)
      else $error("end fields set on non-end word");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_PAYLOAD |-> rsp_payload_byte == 8'h00)
      else $error("payload byte set on non-payload word");

   a_reply_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_valid |->
         ((rsp_end_status == ST_OK) == (rsp_reply_byte == CH_ACK))
         && (rsp_reply_byte == CH_ACK || rsp_reply_byte == CH_NACK))
      else $error("reply byte disagrees with status");

   a_empty_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_END && rsp_end_status == ST_EMPTY |->
         !rsp_reply_valid && rsp_packet_length == '0)
      else $error("empty packet replied or has length");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_packet_length (rsp_packet_length),
   .rsp_end_status    (rsp_end_status),
   .rsp_reply_valid   (rsp_reply_valid),
   .rsp_reply_byte    (rsp_reply_byte)
);
